[rtl/ccs_pkg.sv]
// Package for the connectivity-check scheduler: types, constants and helpers.
// Used by every module in rtl/; depends on nothing.
package ccs_pkg;

  localparam int MaxLocal  = 8;
  localparam int MaxRemote = 8;
  localparam int MaxPairs  = 64;
  localparam int LocIdxW   = $clog2(MaxLocal);
  localparam int RemIdxW   = $clog2(MaxRemote);
  localparam int PairIdxW  = $clog2(MaxPairs);
  localparam int PairCntW  = PairIdxW + 1;
  localparam int CellW     = LocIdxW + RemIdxW;
  localparam logic [3:0] LastClass = 4'd9;

  typedef enum logic [2:0] {
    FuncAddLocal  = 3'd0,
    FuncAddRemote = 3'd1,
    FuncBegin     = 3'd2,
    FuncPoll      = 3'd3,
    FuncResponse  = 3'd4,
    FuncReset     = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    RegProbeInterval = 2'd0,
    RegProbesMax     = 2'd1,
    RegTimeout       = 2'd2,
    RegMaxPairs      = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    StWait    = 2'd0,
    StProbing = 2'd1,
    StSucc    = 2'd2,
    StFailed  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SExec,
    SBuild,
    SPre,
    SMod,
    SPost
  } state_e;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [1:0]  kind;
  } cand_t;

  typedef struct packed {
    logic [LocIdxW-1:0] lidx;
    logic [RemIdxW-1:0] ridx;
    logic [3:0]         cls;
    status_e            st;
    logic [3:0]         probes;
    logic [63:0]        first;
    logic [63:0]        resp;
  } pair_t;

  typedef struct packed {
    logic [31:0] probe_interval_us;
    logic [3:0]  probes_before_failure;
    logic [31:0] overall_timeout_us;
    logic [6:0]  maximum_pairs;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] cand_addr;
    logic [15:0] cand_port;
    logic [1:0]  cand_kind;
    logic        cand_ok;
    logic [63:0] now_us;
  } in_t;

  typedef struct packed {
    logic        send_probe;
    logic [31:0] to_addr;
    logic [15:0] to_port;
    logic [1:0]  to_kind;
    logic [31:0] from_addr;
    logic [15:0] from_port;
    logic [1:0]  from_kind;
    logic        is_connected;
    logic        is_exhausted;
    logic        nominee_valid;
    logic [5:0]  nominee_index;
    logic [63:0] nominee_rtt_us;
  } res_t;

  // Priority in units of 100: larger kind plus both kinds.
  function automatic logic [3:0] pair_class(logic [1:0] ka, logic [1:0] kb);
    logic [3:0] mx;
    mx = (ka > kb) ? {2'b00, ka} : {2'b00, kb};
    return mx + {2'b00, ka} + {2'b00, kb};
  endfunction

endpackage

[rtl/ccs_pair_ram.sv]
// Pair table memory: one write port, one read port, registered read data.
// Depends on ccs_pkg.
module ccs_pair_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [ccs_pkg::PairIdxW-1:0] waddr_i,
  input  ccs_pkg::pair_t               wdata_i,
  input  logic [ccs_pkg::PairIdxW-1:0] raddr_i,
  output ccs_pkg::pair_t               rdata_o
);

  ccs_pkg::pair_t mem_q [ccs_pkg::MaxPairs];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/ccs_cfg_regs.sv]
// APB configuration registers of the scheduler.
// Depends on ccs_pkg.
module ccs_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ccs_pkg::cfg_t cfg_o
);

  ccs_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Decode write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        ccs_pkg::RegProbeInterval: cfg_d.probe_interval_us     = pwdata;
        ccs_pkg::RegProbesMax:     cfg_d.probes_before_failure = pwdata[3:0];
        ccs_pkg::RegTimeout:       cfg_d.overall_timeout_us    = pwdata;
        ccs_pkg::RegMaxPairs:      cfg_d.maximum_pairs         = pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      ccs_pkg::RegProbeInterval: prdata = cfg_q.probe_interval_us;
      ccs_pkg::RegProbesMax:     prdata = {28'd0, cfg_q.probes_before_failure};
      ccs_pkg::RegTimeout:       prdata = cfg_q.overall_timeout_us;
      ccs_pkg::RegMaxPairs:      prdata = {25'd0, cfg_q.maximum_pairs};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_interval_us     <= 32'd200000;
      cfg_q.probes_before_failure <= 4'd5;
      cfg_q.overall_timeout_us    <= 32'd10000000;
      cfg_q.maximum_pairs         <= 7'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/connectivity_check_scheduler.sv]
// Connectivity-check scheduler top level: candidate lists, control sequencer, pair scans.
// Depends on ccs_pkg, ccs_pair_ram and ccs_cfg_regs.
// Begin builds the pair table in ten priority passes over the 8x8 candidate grid.
// One item at a time; the pair memory's single read port walks one pair per cycle.
// Result strobe lasts one cycle; the receiver cannot stall. Reset clears lists and counts.
module connectivity_check_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  ccs_pkg::in_t   item_i,
  output logic           done_o,
  output ccs_pkg::res_t  result_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int LW = ccs_pkg::LocIdxW;
  localparam int RW = ccs_pkg::RemIdxW;
  localparam int PW = ccs_pkg::PairIdxW;
  localparam int CW = ccs_pkg::PairCntW;

  ccs_pkg::cfg_t    cfg;
  ccs_pkg::state_e  state_q, state_d;
  ccs_pkg::in_t     in_q, in_d;
  ccs_pkg::res_t    res_q, res_d;
  ccs_pkg::cand_t   ltab_q [ccs_pkg::MaxLocal];
  ccs_pkg::cand_t   ltab_d [ccs_pkg::MaxLocal];
  ccs_pkg::cand_t   rtab_q [ccs_pkg::MaxRemote];
  ccs_pkg::cand_t   rtab_d [ccs_pkg::MaxRemote];
  logic [LW:0]      lc_q, lc_d;
  logic [RW:0]      rc_q, rc_d;
  logic [CW-1:0]    pc_q, pc_d;
  logic             started_q, started_d;
  logic [63:0]      stime_q, stime_d;
  logic [LW+RW-1:0] cell_q, cell_d;
  logic [3:0]       cls_q, cls_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic [PW-1:0]    rd_idx_q, rd_idx_d;
  logic             stop_q, stop_d;
  logic             any_q, any_d;
  logic             spent_q, spent_d;
  logic             nv_q, nv_d;
  logic [3:0]       bcls_q, bcls_d;
  logic [PW-1:0]    bidx_q, bidx_d;
  logic [63:0]      brtt_q, brtt_d;
  logic             done_q, done_d;

  logic             mem_we;
  logic [PW-1:0]    mem_waddr, mem_raddr;
  ccs_pkg::pair_t   mem_wdata, mem_rdata, e;

  ccs_pkg::cand_t   cand;
  logic             accept, ldup, rdup, scan_end, exh, pre_go, fire, rd_en;
  logic [63:0]      elapsed;
  logic [6:0]       lim;
  logic [LW-1:0]    gl;
  logic [RW-1:0]    gr;
  logic [6:0]       gidx;
  logic             gen_hit, build_end;
  logic [35:0]      prod;
  logic [63:0]      due, rtt;

  ccs_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  ccs_pair_ram u_ram (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign accept   = start_i & ~busy_o;
  assign busy_o   = (state_q != ccs_pkg::SIdle);
  assign done_o   = done_q;
  assign result_o = res_q;
  assign e        = mem_rdata;
  assign cand     = '{addr: in_q.cand_addr, port: in_q.cand_port, kind: in_q.cand_kind};

  // Duplicate search over the candidate lists
  always_comb begin
    ldup = 1'b0;
    rdup = 1'b0;
    for (int i = 0; i < ccs_pkg::MaxLocal; i++) begin
      if ((LW+1)'(i) < lc_q && ltab_q[i] == cand) ldup = 1'b1;
    end
    for (int i = 0; i < ccs_pkg::MaxRemote; i++) begin
      if ((RW+1)'(i) < rc_q && rtab_q[i] == cand) rdup = 1'b1;
    end
  end

  // Pair generation over the candidate grid
  assign lim       = (cfg.maximum_pairs > 7'(ccs_pkg::MaxPairs)) ?
                     7'(ccs_pkg::MaxPairs) : cfg.maximum_pairs;
  assign gl        = cell_q[LW+RW-1:RW];
  assign gr        = cell_q[RW-1:0];
  assign gidx      = 7'(gl) * 7'(rc_q) + 7'(gr);
  assign gen_hit   = ({1'b0, gl} < lc_q) && ({1'b0, gr} < rc_q) && (gidx < lim) &&
                     (ccs_pkg::pair_class(ltab_q[gl].kind, rtab_q[gr].kind) == cls_q);
  assign build_end = (cls_q == ccs_pkg::LastClass) && (&cell_q);

  // Scan status
  assign scan_end = stop_q || (idx_q >= pc_q && !rd_vld_q);
  assign elapsed  = in_q.now_us - stime_q;
  assign exh      = started_q && !any_q &&
                    (elapsed >= {32'd0, cfg.overall_timeout_us} || pc_q == '0 || spent_q);
  assign pre_go   = started_q && !any_q && !exh;
  assign prod     = 36'(e.probes) * 36'(cfg.probe_interval_us);
  assign due      = e.first + 64'(prod);
  assign rtt      = (e.resp > e.first) ? (e.resp - e.first) : 64'd0;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ccs_pkg::SIdle: if (accept) state_d = ccs_pkg::SExec;
      ccs_pkg::SExec: begin
        case (in_q.func)
          ccs_pkg::FuncBegin:    state_d = ccs_pkg::SBuild;
          ccs_pkg::FuncPoll:     state_d = ccs_pkg::SPre;
          ccs_pkg::FuncResponse: state_d = ccs_pkg::SMod;
          default:               state_d = ccs_pkg::SPost;
        endcase
      end
      ccs_pkg::SBuild: if (build_end) state_d = ccs_pkg::SPost;
      ccs_pkg::SPre: if (scan_end) state_d = pre_go ? ccs_pkg::SMod : ccs_pkg::SPost;
      ccs_pkg::SMod: if (scan_end) state_d = ccs_pkg::SPost;
      ccs_pkg::SPost: if (scan_end) state_d = ccs_pkg::SIdle;
      default: state_d = ccs_pkg::SIdle;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    logic scan_init;
    scan_init = 1'b0;
    in_d      = in_q;
    res_d     = res_q;
    ltab_d    = ltab_q;
    rtab_d    = rtab_q;
    lc_d      = lc_q;
    rc_d      = rc_q;
    pc_d      = pc_q;
    started_d = started_q;
    stime_d   = stime_q;
    cell_d    = cell_q;
    cls_d     = cls_q;
    idx_d     = idx_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    stop_d    = stop_q;
    any_d     = any_q;
    spent_d   = spent_q;
    nv_d      = nv_q;
    bcls_d    = bcls_q;
    bidx_d    = bidx_q;
    brtt_d    = brtt_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = e;
    mem_raddr = idx_q[PW-1:0];
    fire      = 1'b0;
    rd_en     = 1'b0;

    case (state_q)
      ccs_pkg::SIdle: begin
        if (accept) begin
          in_d  = item_i;
          res_d = '0;
        end
      end

      ccs_pkg::SExec: begin
        scan_init = 1'b1;
        case (in_q.func)
          ccs_pkg::FuncAddLocal: begin
            if (in_q.cand_ok && !ldup && lc_q < (LW+1)'(ccs_pkg::MaxLocal)) begin
              ltab_d[lc_q[LW-1:0]] = cand;
              lc_d = lc_q + 1'b1;
            end
          end
          ccs_pkg::FuncAddRemote: begin
            if (in_q.cand_ok && !rdup && rc_q < (RW+1)'(ccs_pkg::MaxRemote)) begin
              rtab_d[rc_q[RW-1:0]] = cand;
              rc_d = rc_q + 1'b1;
            end
          end
          ccs_pkg::FuncBegin: begin
            scan_init = 1'b0;
            pc_d      = '0;
            cell_d    = '0;
            cls_d     = '0;
          end
          ccs_pkg::FuncReset: begin
            lc_d      = '0;
            rc_d      = '0;
            pc_d      = '0;
            stime_d   = '0;
            started_d = 1'b0;
          end
          default: ;
        endcase
      end

      ccs_pkg::SBuild: begin
        // Write pairs of the current priority class in local-major order
        if (gen_hit) begin
          mem_we    = 1'b1;
          mem_waddr = pc_q[PW-1:0];
          mem_wdata = '{lidx: gl, ridx: gr, cls: cls_q, st: ccs_pkg::StWait,
                        probes: 4'd0, first: 64'd0, resp: 64'd0};
          pc_d      = pc_q + 1'b1;
        end
        cell_d = cell_q + 1'b1;
        if (&cell_q) cls_d = cls_q + 1'b1;
        if (build_end) begin
          stime_d   = in_q.now_us;
          started_d = 1'b1;
          scan_init = 1'b1;
        end
      end

      ccs_pkg::SPre, ccs_pkg::SMod, ccs_pkg::SPost: begin
        // Process the entry read last cycle
        if (rd_vld_q && !stop_q) begin
          if (state_q == ccs_pkg::SMod && in_q.func == ccs_pkg::FuncPoll) begin
            if (e.st != ccs_pkg::StSucc && e.st != ccs_pkg::StFailed) begin
              if (e.probes >= cfg.probes_before_failure) begin
                mem_we    = 1'b1;
                mem_wdata.st = ccs_pkg::StFailed;
              end else if (e.probes == 4'd0 || in_q.now_us >= due) begin
                fire             = 1'b1;
                stop_d           = 1'b1;
                mem_we           = 1'b1;
                mem_wdata.st     = ccs_pkg::StProbing;
                mem_wdata.probes = e.probes + 1'b1;
                if (e.probes == 4'd0) mem_wdata.first = in_q.now_us;
                res_d.send_probe = 1'b1;
                res_d.to_addr    = rtab_q[e.ridx].addr;
                res_d.to_port    = rtab_q[e.ridx].port;
                res_d.to_kind    = rtab_q[e.ridx].kind;
                res_d.from_addr  = ltab_q[e.lidx].addr;
                res_d.from_port  = ltab_q[e.lidx].port;
                res_d.from_kind  = ltab_q[e.lidx].kind;
              end
            end
          end else if (state_q == ccs_pkg::SMod) begin
            if (rtab_q[e.ridx] == cand && e.st != ccs_pkg::StFailed &&
                e.st != ccs_pkg::StSucc) begin
              mem_we         = 1'b1;
              mem_wdata.st   = ccs_pkg::StSucc;
              mem_wdata.resp = in_q.now_us;
            end
          end else begin
            // Accumulate connected, spent and nominee
            if (e.st == ccs_pkg::StSucc) begin
              any_d = 1'b1;
              if (!nv_q || e.cls < bcls_q) begin
                nv_d   = 1'b1;
                bcls_d = e.cls;
                bidx_d = rd_idx_q;
                brtt_d = rtt;
              end
            end
            if (e.st != ccs_pkg::StFailed && e.probes < cfg.probes_before_failure) begin
              spent_d = 1'b0;
            end
          end
        end
        // Issue the next read
        rd_en = (idx_q < pc_q) && !stop_q && !fire;
        if (rd_en) begin
          idx_d    = idx_q + 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[PW-1:0];
        end
        if (scan_end) begin
          if (state_q == ccs_pkg::SPost) begin
            res_d.is_connected   = any_q;
            res_d.is_exhausted   = exh;
            res_d.nominee_valid  = nv_q;
            res_d.nominee_index  = 6'(bidx_q);
            res_d.nominee_rtt_us = brtt_q;
            done_d               = 1'b1;
          end else begin
            scan_init = 1'b1;
          end
        end
      end

      default: ;
    endcase

    // Restart the scan from the first pair
    if (scan_init) begin
      idx_d    = '0;
      rd_vld_d = 1'b0;
      stop_d   = 1'b0;
      any_d    = 1'b0;
      spent_d  = 1'b1;
      nv_d     = 1'b0;
      bcls_d   = '0;
      bidx_d   = '0;
      brtt_d   = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ccs_pkg::SIdle;
      lc_q      <= '0;
      rc_q      <= '0;
      pc_q      <= '0;
      started_q <= 1'b0;
      stime_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      stop_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      lc_q      <= lc_d;
      rc_q      <= rc_d;
      pc_q      <= pc_d;
      started_q <= started_d;
      stime_q   <= stime_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      stop_q    <= stop_d;
      done_q    <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    res_q    <= res_d;
    ltab_q   <= ltab_d;
    rtab_q   <= rtab_d;
    cell_q   <= cell_d;
    cls_q    <= cls_d;
    rd_idx_q <= rd_idx_d;
    any_q    <= any_d;
    spent_q  <= spent_d;
    nv_q     <= nv_d;
    bcls_q   <= bcls_d;
    bidx_q   <= bidx_d;
    brtt_q   <= brtt_d;
  end

  // Checks
  a_done_after_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ccs_pkg::SPost)) else $error("result without final scan");
  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= CW'(ccs_pkg::MaxPairs)) else $error("pair count overflow");
  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ccs_pkg::SIdle) |-> !rd_vld_q) else $error("read in flight while idle");
  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lc_q <= (LW+1)'(ccs_pkg::MaxLocal)) && (rc_q <= (RW+1)'(ccs_pkg::MaxRemote)))
    else $error("candidate count overflow");

endmodule
